[rtl/iccr_pkg.sv]
`default_nettype none

package iccr_pkg;

  localparam logic       FUNC_READ  = 1'b0;
  localparam logic       FUNC_WRITE = 1'b1;

  localparam logic [15:0] PORT_MAIN_INDEX = 16'h0022;
  localparam logic [15:0] PORT_MAIN_DATA  = 16'h0023;
  localparam logic [16:0] DATA_PORT_OFFSET = 17'd4;

  localparam logic [7:0] REG_WIN_SEL    = 8'h10;
  localparam logic [7:0] REG_BASE_LO    = 8'h12;
  localparam logic [7:0] REG_BASE_HI    = 8'h13;
  localparam logic [7:0] REG_MASK_21    = 8'h21;
  localparam logic [7:0] REG_MASK_22    = 8'h22;
  localparam logic [7:0] REG_SHADOW_C   = 8'h25;
  localparam logic [7:0] REG_SHADOW_D   = 8'h26;
  localparam logic [7:0] REG_SHADOW_E   = 8'h27;
  localparam logic [7:0] REG_SHADOW_F   = 8'h28;
  localparam logic [7:0] REG_MASK_29    = 8'h29;
  localparam logic [7:0] REG_MASK_36    = 8'h36;
  localparam logic [7:0] REG_RESET_ONES = 8'h7b;

  localparam logic [7:0] SEL_HOST  = 8'h07;
  localparam logic [7:0] SEL_LOCAL = 8'h06;

  localparam logic [7:0] BYTE_ONES = 8'hff;

  typedef struct packed {
    logic        func;
    logic [15:0] port_address;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [12:0] shadow_read_map;
    logic [12:0] shadow_write_map;
    logic        bios_shadow_read;
    logic        bios_shadow_write;
    logic        smram_open;
  } rsp_t;

  // Port decode hits, an index hit and a data hit per decoder
  typedef struct packed {
    logic main_idx;
    logic main_dat;
    logic host_idx;
    logic host_dat;
    logic loc_idx;
    logic loc_dat;
  } hit_t;

  function automatic logic [7:0] mask_main(input logic [7:0] idx, input logic [7:0] v);
    logic [7:0] r;
    begin
      unique case (idx)
        REG_MASK_21:  r = v & 8'hfe;
        REG_MASK_22:  r = v & 8'h7f;
        REG_SHADOW_F: r = v & 8'he3;
        REG_MASK_29:  r = v & 8'h0f;
        REG_MASK_36:  r = v & 8'h3f;
        default:      r = v;
      endcase
      return r;
    end
  endfunction

  // Region 4r+b: write enable bit 2b, read enable bit 2b+1 of register 25h+r.
  function automatic rsp_t shadow_status(input logic [7:0] r25, input logic [7:0] r26,
                                         input logic [7:0] r27, input logic [7:0] r28);
    rsp_t s;
    logic [23:0] regs;
    begin
      s = '0;
      regs = {r27, r26, r25};
      for (int i = 0; i < 12; i++) begin
        s.shadow_write_map[i] = regs[2*i];
        s.shadow_read_map[i]  = regs[2*i+1];
      end
      s.shadow_write_map[12] = r28[0];
      s.shadow_read_map[12]  = r28[1];
      s.bios_shadow_read  = |s.shadow_read_map[12:8];
      s.bios_shadow_write = |s.shadow_write_map[12:8];
      s.smram_open        = r28[7];
      s.read_data         = BYTE_ONES;
      return s;
    end
  endfunction

endpackage

`default_nettype wire

[rtl/iccr_ram.sv]
`default_nettype none

module iccr_ram (
  input  wire logic       clk,
  input  wire logic       we,
  input  wire logic [7:0] waddr,
  input  wire logic [7:0] wdata,
  input  wire logic [7:0] raddr,
  output logic      [7:0] rdata
);

  logic [7:0] mem [256];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/iccr_decode.sv]
`default_nettype none

module iccr_decode (
  input  wire logic [15:0] port_address,
  input  wire logic [15:0] hwin_base,
  input  wire logic [15:0] local_base,
  output iccr_pkg::hit_t   hit
);

  logic [16:0] port_ext;
  logic        host_on;
  logic        local_on;

  assign port_ext = {1'b0, port_address};
  assign host_on  = (hwin_base != 16'h0000);
  assign local_on = (local_base != 16'h0000);

  // data port sits at base+4 with no wrap past FFFFh
  always_comb begin
    hit.main_idx = (port_address == iccr_pkg::PORT_MAIN_INDEX);
    hit.main_dat = (port_address == iccr_pkg::PORT_MAIN_DATA);
    hit.host_idx = host_on && (port_address == hwin_base);
    hit.host_dat = host_on &&
                   (port_ext == ({1'b0, hwin_base} + iccr_pkg::DATA_PORT_OFFSET));
    hit.loc_idx  = local_on && (port_address == local_base);
    hit.loc_dat  = local_on &&
                   (port_ext == ({1'b0, local_base} + iccr_pkg::DATA_PORT_OFFSET));
  end

endmodule

`default_nettype wire

[rtl/indexed_chipset_config_registers.sv]
// Result: with a free output register, a transfer on req is held as an item and then
//   executes into rsp; a held result delays it until rsp is taken.
// Flow: no new item is taken until the held one executes; each memory is read at its
//   current index while the item is held and written back when it executes, so req_ready
//   stays low while an item is held. Reset: synchronous, active high; afterwards a
//   clearing pass writes the memories (FFh to 7Bh, zero elsewhere), req_ready low.
`default_nettype none

module indexed_chipset_config_registers (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire iccr_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output iccr_pkg::rsp_t      rsp
);

  // Control and index state
  logic           clearing;
  logic [7:0]     clr_cnt;
  logic           busy;
  iccr_pkg::req_t item;
  logic [7:0]     main_index;
  logic [7:0]     host_index;
  logic [7:0]     local_index;
  logic [15:0]    hwin_base;
  logic [15:0]    local_base;

  // Mirrors of main registers that drive logic directly
  logic [7:0]     reg_sel;
  logic [7:0]     reg_25;
  logic [7:0]     reg_26;
  logic [7:0]     reg_27;
  logic [7:0]     reg_28;

  // Memory ports
  logic           main_we, host_we, local_we;
  logic [7:0]     main_waddr, host_waddr, local_waddr;
  logic [7:0]     main_wdata, host_wdata, local_wdata;
  logic [7:0]     main_rdata, host_rdata, local_rdata;

  iccr_pkg::hit_t hit;
  logic           accept;
  logic           exec;
  logic           is_wr;
  logic           main_wr;
  logic [7:0]     main_val;
  logic [7:0]     rd;
  iccr_pkg::rsp_t result;
  logic [7:0]     reg_25_next, reg_26_next, reg_27_next, reg_28_next;

  assign req_ready = !clearing && !busy;
  assign accept    = req_valid && req_ready;
  // execute as soon as the output register can take the result
  assign exec      = busy && (!rsp_valid || rsp_ready);
  assign is_wr     = (item.func == iccr_pkg::FUNC_WRITE);
  assign main_wr   = exec && is_wr && hit.main_dat;
  assign main_val  = iccr_pkg::mask_main(main_index, item.write_data);

  iccr_decode u_decode (
    .port_address (item.port_address),
    .hwin_base    (hwin_base),
    .local_base   (local_base),
    .hit          (hit)
  );

  // Memories read continuously at the live index; stable while an item waits
  always_comb begin
    if (clearing) begin
      main_we     = 1'b1;
      main_waddr  = clr_cnt;
      main_wdata  = (clr_cnt == iccr_pkg::REG_RESET_ONES) ? iccr_pkg::BYTE_ONES : 8'h00;
      host_we     = 1'b1;
      host_waddr  = clr_cnt;
      host_wdata  = 8'h00;
      local_we    = 1'b1;
      local_waddr = clr_cnt;
      local_wdata = 8'h00;
    end else begin
      main_we     = main_wr;
      main_waddr  = main_index;
      main_wdata  = main_val;
      host_we     = exec && is_wr && hit.host_dat;
      host_waddr  = host_index;
      host_wdata  = item.write_data;
      local_we    = exec && is_wr && hit.loc_dat;
      local_waddr = local_index;
      local_wdata = item.write_data;
    end
  end

  iccr_ram u_main_ram (
    .clk   (clk),
    .we    (main_we),
    .waddr (main_waddr),
    .wdata (main_wdata),
    .raddr (main_index),
    .rdata (main_rdata)
  );

  iccr_ram u_host_ram (
    .clk   (clk),
    .we    (host_we),
    .waddr (host_waddr),
    .wdata (host_wdata),
    .raddr (host_index),
    .rdata (host_rdata)
  );

  iccr_ram u_local_ram (
    .clk   (clk),
    .we    (local_we),
    .waddr (local_waddr),
    .wdata (local_wdata),
    .raddr (local_index),
    .rdata (local_rdata)
  );

  // Read byte: AND over every matching decoder on a read; FFh on a write
  always_comb begin
    rd = iccr_pkg::BYTE_ONES;
    if (!is_wr) begin
      if (hit.main_idx) rd = rd & main_index;
      if (hit.main_dat) rd = rd & main_rdata;
      if (hit.host_idx) rd = rd & host_index;
      if (hit.host_dat) rd = rd & host_rdata;
      if (hit.loc_idx)  rd = rd & local_index;
      if (hit.loc_dat)  rd = rd & local_rdata;
    end
  end

  // Shadow mirrors after this item's write
  always_comb begin
    reg_25_next = reg_25;
    reg_26_next = reg_26;
    reg_27_next = reg_27;
    reg_28_next = reg_28;
    if (is_wr && hit.main_dat) begin
      if (main_index == iccr_pkg::REG_SHADOW_C) reg_25_next = main_val;
      if (main_index == iccr_pkg::REG_SHADOW_D) reg_26_next = main_val;
      if (main_index == iccr_pkg::REG_SHADOW_E) reg_27_next = main_val;
      if (main_index == iccr_pkg::REG_SHADOW_F) reg_28_next = main_val;
    end
    result = iccr_pkg::shadow_status(reg_25_next, reg_26_next, reg_27_next, reg_28_next);
    result.read_data = rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing    <= 1'b1;
      clr_cnt     <= 8'h00;
      busy        <= 1'b0;
      rsp_valid   <= 1'b0;
      main_index  <= 8'h00;
      host_index  <= 8'h00;
      local_index <= 8'h00;
      hwin_base   <= 16'h0000;
      local_base  <= 16'h0000;
      reg_sel     <= 8'h00;
      reg_25      <= 8'h00;
      reg_26      <= 8'h00;
      reg_27      <= 8'h00;
      reg_28      <= 8'h00;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + 8'd1;
        if (clr_cnt == 8'hff) begin
          clearing <= 1'b0;
        end
      end

      if (rsp_valid && rsp_ready && !exec) begin
        rsp_valid <= 1'b0;
      end

      if (accept) begin
        item <= req;
        busy <= 1'b1;
      end

      if (exec) begin
        busy      <= 1'b0;
        rsp_valid <= 1'b1;
        rsp       <= result;
        reg_25    <= reg_25_next;
        reg_26    <= reg_26_next;
        reg_27    <= reg_27_next;
        reg_28    <= reg_28_next;
        if (is_wr) begin
          if (hit.host_idx) host_index <= item.write_data;
          if (hit.loc_idx)  local_index <= item.write_data;
          if (hit.main_idx) main_index <= item.write_data;
          if (hit.main_dat) begin
            if (main_index == iccr_pkg::REG_WIN_SEL) reg_sel <= main_val;
            // window base bytes follow the select value from before this write
            if (main_index == iccr_pkg::REG_BASE_LO) begin
              if (reg_sel == iccr_pkg::SEL_HOST) begin
                hwin_base[7:0] <= item.write_data;
              end else if (reg_sel == iccr_pkg::SEL_LOCAL) begin
                local_base[7:0] <= item.write_data;
              end
            end
            if (main_index == iccr_pkg::REG_BASE_HI) begin
              if (reg_sel == iccr_pkg::SEL_HOST) begin
                hwin_base[15:8] <= item.write_data;
              end else if (reg_sel == iccr_pkg::SEL_LOCAL) begin
                local_base[15:8] <= item.write_data;
              end
            end
          end
        end
      end
    end
  end

  // No transfer on req while the clearing pass runs
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !req_ready)
    else $error("req_ready during clearing pass");

  // An accepted item is held in the next cycle to wait for execution
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted item not held");

  // With a free output register a held item completes at once
  a_exec_done: assert property (@(posedge clk) disable iff (rst)
    (busy && !rsp_valid) |=> (!busy && rsp_valid))
    else $error("held item did not complete");

  // A write always returns FFh
  a_write_ff: assert property (@(posedge clk) disable iff (rst)
    (exec && is_wr) |=> (rsp.read_data == iccr_pkg::BYTE_ONES))
    else $error("write returned data");

endmodule

`default_nettype wire

[sim/indexed_chipset_config_registers_tb.sv]
`timescale 1ns / 1ps

module indexed_chipset_config_registers_tb;
  import iccr_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 8;
  // Covers the clearing pass after reset, the long hold-off and the longest random gaps.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int TAIL_CYCLES    = 4;
  localparam int MAX_REPORTS    = 10;

  // Expected replies for the I/O port decoder, plus the compare against what comes back.
  class io_reply_tracker;
    logic [7:0]  main_index;
    logic [7:0]  main_regs[256];
    logic [15:0] hwin_base;
    logic [7:0]  host_index;
    logic [7:0]  hwin_regs[256];
    logic [15:0] local_base;
    logic [7:0]  local_index;
    logic [7:0]  local_regs[256];
    rsp_t        replies_due[$];
    int unsigned reads, writes, replies_seen, mismatches, base_moves;

    function new();
      foreach (main_regs[i]) begin
        main_regs[i]  = '0;
        hwin_regs[i]  = '0;
        local_regs[i] = '0;
      end
      main_regs[REG_RESET_ONES] = BYTE_ONES;
      main_index  = '0;
      hwin_base   = '0;
      host_index  = '0;
      local_base  = '0;
      local_index = '0;
    endfunction

    function bit index_hit(logic [15:0] base, logic [15:0] port);
      return base != 16'h0000 && port == base;
    endfunction

    // No wrap past FFFFh: a base above FFFBh has no data port.
    function bit data_hit(logic [15:0] base, logic [15:0] port);
      return base != 16'h0000 && {1'b0, port} == {1'b0, base} + DATA_PORT_OFFSET;
    endfunction

    function logic [7:0] masked_byte(logic [7:0] idx, logic [7:0] v);
      case (idx)
        REG_MASK_21:  return v & 8'hfe;
        REG_MASK_22:  return v & 8'h7f;
        REG_SHADOW_F: return v & 8'he3;
        REG_MASK_29:  return v & 8'h0f;
        REG_MASK_36:  return v & 8'h3f;
        default:      return v;
      endcase
    endfunction

    // Applies one access to the register state and returns the reply it produces.
    function rsp_t predict_reply(req_t a);
      rsp_t        r;
      logic [7:0]  rd, v, hi, li, idx;
      logic [15:0] hb, lb, port;
      logic [23:0] shadow;
      rd   = BYTE_ONES;
      v    = a.write_data;
      port = a.port_address;
      hb   = hwin_base;
      lb   = local_base;
      hi   = host_index;
      li   = local_index;
      if (a.func == FUNC_READ) begin
        if (port == PORT_MAIN_INDEX) rd &= main_index;
        if (port == PORT_MAIN_DATA)  rd &= main_regs[main_index];
        if (index_hit(hb, port))     rd &= hi;
        if (data_hit(hb, port))      rd &= hwin_regs[hi];
        if (index_hit(lb, port))     rd &= li;
        if (data_hit(lb, port))      rd &= local_regs[li];
      end else begin
        // every decoder sees the pre-access state
        if (index_hit(hb, port)) host_index = v;
        if (data_hit(hb, port))  hwin_regs[hi] = v;
        if (index_hit(lb, port)) local_index = v;
        if (data_hit(lb, port))  local_regs[li] = v;
        if (port == PORT_MAIN_INDEX) begin
          main_index = v;
        end else if (port == PORT_MAIN_DATA) begin
          idx = main_index;
          if (idx == REG_BASE_LO || idx == REG_BASE_HI) begin
            if (main_regs[REG_WIN_SEL] == SEL_HOST) begin
              hwin_base = (idx == REG_BASE_LO) ? {hb[15:8], v} : {v, hb[7:0]};
              base_moves++;
            end else if (main_regs[REG_WIN_SEL] == SEL_LOCAL) begin
              local_base = (idx == REG_BASE_LO) ? {lb[15:8], v} : {v, lb[7:0]};
              base_moves++;
            end
          end
          main_regs[idx] = masked_byte(idx, v);
        end
      end
      shadow = {main_regs[REG_SHADOW_E], main_regs[REG_SHADOW_D], main_regs[REG_SHADOW_C]};
      r = '0;
      r.read_data = rd;
      for (int i = 0; i < 12; i++) begin
        r.shadow_write_map[i] = shadow[2*i];
        r.shadow_read_map[i]  = shadow[2*i+1];
      end
      r.shadow_write_map[12] = main_regs[REG_SHADOW_F][0];
      r.shadow_read_map[12]  = main_regs[REG_SHADOW_F][1];
      r.bios_shadow_read     = |r.shadow_read_map[12:8];
      r.bios_shadow_write    = |r.shadow_write_map[12:8];
      r.smram_open           = main_regs[REG_SHADOW_F][7];
      return r;
    endfunction

    function void note_access(req_t a);
      if (a.func == FUNC_READ) reads++;
      else writes++;
      replies_due.push_back(predict_reply(a));
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("reply %0d: %s", replies_seen, what);
    endfunction

    function void check_reply(rsp_t got);
      rsp_t want;
      replies_seen++;
      if (replies_due.size() == 0) begin
        flag($sformatf("unexpected reply %h", got));
        return;
      end
      want = replies_due.pop_front();
      if (got.read_data !== want.read_data)
        flag($sformatf("read_data exp %02h got %02h", want.read_data, got.read_data));
      if (got.shadow_read_map !== want.shadow_read_map)
        flag($sformatf("shadow_read_map exp %04h got %04h",
                       want.shadow_read_map, got.shadow_read_map));
      if (got.shadow_write_map !== want.shadow_write_map)
        flag($sformatf("shadow_write_map exp %04h got %04h",
                       want.shadow_write_map, got.shadow_write_map));
      if (got.bios_shadow_read !== want.bios_shadow_read)
        flag($sformatf("bios_shadow_read exp %b got %b",
                       want.bios_shadow_read, got.bios_shadow_read));
      if (got.bios_shadow_write !== want.bios_shadow_write)
        flag($sformatf("bios_shadow_write exp %b got %b",
                       want.bios_shadow_write, got.bios_shadow_write));
      if (got.smram_open !== want.smram_open)
        flag($sformatf("smram_open exp %b got %b", want.smram_open, got.smram_open));
    endfunction

    function int pending();
      return replies_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  io_reply_tracker book = new();

  // Idle mix, changed by the stimulus between phases.
  int unsigned req_idle_pct  = 0;
  int unsigned rsp_stall_pct = 0;
  int unsigned accesses_sent = 0;

  // Hold-off handshake: stimulus bumps holdoff_asked, the receiver counts it out.
  int unsigned holdoff_asked  = 0;
  int unsigned holdoff_served = 0;
  int unsigned holdoff_left   = 0;

  int unsigned quiet_cycles = 0;

  indexed_chipset_config_registers dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Receiver side: random stalls, or a long hold-off when asked for one.
  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_served != holdoff_asked) begin
        holdoff_served = holdoff_asked;
        holdoff_left   = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
    end
  end

  // Reply monitor: every transfer on rsp is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) book.check_reply(rsp);
  end

  // Watchdog: too long without a transfer on either side ends the run.
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d replies outstanding",
                 quiet_cycles, book.pending());
        $display("indexed_chipset_config_registers regression: fail");
        $finish;
      end
    end
  end

  // One byte access. Called and returns at a falling edge; valid stays up until the
  // transfer, and the expectation is recorded at the accepting edge.
  task automatic io_access(input logic f, input logic [15:0] port, input logic [7:0] d);
    req_t a;
    a.func         = f;
    a.port_address = port;
    a.write_data   = d;
    while ($urandom_range(99) < req_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req       <= a;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_ready !== 1'b1);
    book.note_access(a);
    accesses_sent++;
    @(negedge clk);
  endtask

  task automatic write_main(input logic [7:0] idx, input logic [7:0] v);
    io_access(FUNC_WRITE, PORT_MAIN_INDEX, idx);
    io_access(FUNC_WRITE, PORT_MAIN_DATA, v);
  endtask

  // Select a window through 10h, then load its base low byte and high byte.
  task automatic move_window(input logic [7:0] sel, input logic [15:0] base);
    write_main(REG_WIN_SEL, sel);
    write_main(REG_BASE_LO, base[7:0]);
    write_main(REG_BASE_HI, base[15:8]);
  endtask

  function automatic logic [7:0] pick_main_index();
    case ($urandom_range(15))
      0:       return REG_WIN_SEL;
      1:       return REG_BASE_LO;
      2:       return REG_BASE_HI;
      3:       return REG_MASK_21;
      4:       return REG_MASK_22;
      5:       return REG_SHADOW_C;
      6:       return REG_SHADOW_D;
      7:       return REG_SHADOW_E;
      8:       return REG_SHADOW_F;
      9:       return REG_MASK_29;
      10:      return REG_MASK_36;
      11:      return REG_RESET_ONES;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] pick_window_sel();
    case ($urandom_range(9))
      0, 1, 2, 3: return SEL_HOST;
      4, 5, 6, 7: return SEL_LOCAL;
      default:    return 8'($urandom_range(255));
    endcase
  endfunction

  // Bases biased toward the corner cases: off, overlapping 22h/23h, near FFFFh, and
  // stacked on or next to the other window.
  function automatic logic [15:0] pick_window_base();
    logic [15:0] other;
    other = $urandom_range(1) ? book.hwin_base : book.local_base;
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'h001e + 16'($urandom_range(5));
      2:       return 16'hfff8 + 16'($urandom_range(7));
      3:       return other;
      4:       return $urandom_range(1) ? other + 16'd4 : other - 16'd4;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // Random traffic: window moves, bursts on the main pair, bursts on a window, noise.
  task automatic run_phase(input int unsigned count);
    int unsigned stop_at, k;
    logic [15:0] base;
    stop_at = accesses_sent + count;
    while (accesses_sent < stop_at) begin
      k = $urandom_range(99);
      if (k < 12) begin
        move_window(pick_window_sel(), pick_window_base());
      end else if (k < 45) begin
        io_access(FUNC_WRITE, PORT_MAIN_INDEX, pick_main_index());
        repeat ($urandom_range(1, 3))
          io_access(1'($urandom_range(1)), PORT_MAIN_DATA, 8'($urandom_range(255)));
        if ($urandom_range(3) == 0)
          io_access(FUNC_READ, PORT_MAIN_INDEX, 8'($urandom_range(255)));
      end else if (k < 80) begin
        base = $urandom_range(1) ? book.hwin_base : book.local_base;
        if (base == 16'h0000) begin
          move_window(pick_window_sel(), pick_window_base());
        end else begin
          repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(6))
              0, 1:    io_access(1'($urandom_range(1)), base, 8'($urandom_range(255)));
              2, 3, 4: io_access(1'($urandom_range(1)), base + 16'd4,
                                 8'($urandom_range(255)));
              default: io_access(1'($urandom_range(1)), base + 16'($urandom_range(1, 3)),
                                 8'($urandom_range(255)));
            endcase
          end
        end
      end else begin
        io_access(1'($urandom_range(1)),
                  $urandom_range(1) ? 16'($urandom_range(65535))
                                    : 16'h0020 + 16'($urandom_range(7)),
                  8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset values, unmatched ports, a masked register, the shadow decode,
    // a window parked above FFFBh and both windows stacked on one port.
    io_access(FUNC_READ, PORT_MAIN_INDEX, 8'h00);
    io_access(FUNC_READ, PORT_MAIN_DATA, 8'hff);
    io_access(FUNC_WRITE, 16'hffff, 8'h00);
    io_access(FUNC_READ, 16'h0000, 8'hff);
    io_access(FUNC_WRITE, PORT_MAIN_INDEX, REG_RESET_ONES);
    io_access(FUNC_READ, PORT_MAIN_DATA, 8'h00);
    write_main(REG_SHADOW_F, 8'hff);
    write_main(REG_SHADOW_E, 8'hff);
    move_window(SEL_HOST, 16'hfffc);
    io_access(FUNC_WRITE, 16'hfffc, 8'h55);
    io_access(FUNC_READ, 16'hfffc, 8'h00);
    move_window(SEL_LOCAL, 16'hfffc);
    io_access(FUNC_READ, 16'hfffc, 8'hff);

    // No idling at all.
    req_idle_pct  = 0;
    rsp_stall_pct = 0;
    run_phase(230);

    // Sender mostly idle.
    req_idle_pct = 76;
    run_phase(200);

    // Receiver mostly stalling.
    req_idle_pct  = 0;
    rsp_stall_pct = 76;
    run_phase(200);

    // Light idling on both sides.
    req_idle_pct  = 7;
    rsp_stall_pct = 7;
    run_phase(200);

    // Receiver holds off while the sender keeps offering, so the block backs up.
    req_idle_pct  = 0;
    rsp_stall_pct = 0;
    holdoff_asked++;
    run_phase(100);

    req_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d accesses (%0d reads, %0d writes), %0d replies, %0d base loads.",
             accesses_sent, book.reads, book.writes, book.replies_seen, book.base_moves);
    $display("Idle: none, sender 76%%, receiver 76%%, both 7%%, %0d-cycle hold-off; %0d bad.",
             HOLDOFF_CYCLES, book.mismatches);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("indexed_chipset_config_registers regression: pass");
    end else begin
      $display("indexed_chipset_config_registers regression: fail");
    end
    $finish;
  end

endmodule
